// ===== hw/rtl/pbr_pkg.sv =====
// Shared types, constants and the sequencer microcode for the bisection root finder.
// No dependencies; every other file imports this package.
package pbr_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 24;
  localparam int TOL_W       = 31;
  localparam int NUM_COEFF   = 5;
  localparam int COEFF_IDX_W = $clog2(NUM_COEFF);
  localparam int K_W         = $clog2(NUM_COEFF - 1);
  localparam int PROD_W      = 2 * WORD_W;
  localparam int SUM_W       = PROD_W - FRAC_W + 1;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [TOL_W-1:0]         tol_t;

  localparam word_t COEFF0_RST = -32'sd16777216;
  localparam word_t COEFF1_RST = -32'sd16777216;
  localparam word_t COEFF2_RST = 32'sd0;
  localparam word_t COEFF3_RST = 32'sd33554432;
  localparam word_t COEFF4_RST = 32'sd16777216;
  localparam tol_t  TOL_RST    = 31'd16777;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_COEFF0 = 3'd0,
    REG_COEFF1 = 3'd1,
    REG_COEFF2 = 3'd2,
    REG_COEFF3 = 3'd3,
    REG_COEFF4 = 3'd4,
    REG_TOL    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    word_t [NUM_COEFF-1:0] coeff;
    tol_t                  tolerance;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_LOAD_X,
    OP_MUL,
    OP_ACC,
    OP_SIGN_A,
    OP_CHK_B,
    OP_TEST,
    OP_UPDATE,
    OP_RESULT
  } op_e;

  typedef enum logic [1:0] {
    XSEL_A,
    XSEL_B,
    XSEL_MID
  } xsel_e;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 4'd0;
  localparam step_t STEP_LOAD_A = 4'd1;
  localparam step_t STEP_MUL_A  = 4'd2;
  localparam step_t STEP_ACC_A  = 4'd3;
  localparam step_t STEP_SIGN_A = 4'd4;
  localparam step_t STEP_LOAD_B = 4'd5;
  localparam step_t STEP_MUL_B  = 4'd6;
  localparam step_t STEP_ACC_B  = 4'd7;
  localparam step_t STEP_CHK_B  = 4'd8;
  localparam step_t STEP_TEST   = 4'd9;
  localparam step_t STEP_LOAD_C = 4'd10;
  localparam step_t STEP_MUL_C  = 4'd11;
  localparam step_t STEP_ACC_C  = 4'd12;
  localparam step_t STEP_UPDATE = 4'd13;
  localparam step_t STEP_RESULT = 4'd14;

  typedef struct packed {
    op_e   op;
    xsel_e xsel;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic horner_last;
    logic same_sign;
    logic narrow;
    logic slot_free;
  } dp_status_t;

  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    w = '{op: OP_WAIT, xsel: XSEL_A, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT:   w = '{op: OP_WAIT,   xsel: XSEL_A,   target: STEP_WAIT};
      STEP_LOAD_A: w = '{op: OP_LOAD_X, xsel: XSEL_A,   target: STEP_WAIT};
      STEP_MUL_A:  w = '{op: OP_MUL,    xsel: XSEL_A,   target: STEP_WAIT};
      STEP_ACC_A:  w = '{op: OP_ACC,    xsel: XSEL_A,   target: STEP_MUL_A};
      STEP_SIGN_A: w = '{op: OP_SIGN_A, xsel: XSEL_A,   target: STEP_WAIT};
      STEP_LOAD_B: w = '{op: OP_LOAD_X, xsel: XSEL_B,   target: STEP_WAIT};
      STEP_MUL_B:  w = '{op: OP_MUL,    xsel: XSEL_B,   target: STEP_WAIT};
      STEP_ACC_B:  w = '{op: OP_ACC,    xsel: XSEL_B,   target: STEP_MUL_B};
      STEP_CHK_B:  w = '{op: OP_CHK_B,  xsel: XSEL_B,   target: STEP_RESULT};
      STEP_TEST:   w = '{op: OP_TEST,   xsel: XSEL_MID, target: STEP_RESULT};
      STEP_LOAD_C: w = '{op: OP_LOAD_X, xsel: XSEL_MID, target: STEP_WAIT};
      STEP_MUL_C:  w = '{op: OP_MUL,    xsel: XSEL_MID, target: STEP_WAIT};
      STEP_ACC_C:  w = '{op: OP_ACC,    xsel: XSEL_MID, target: STEP_MUL_C};
      STEP_UPDATE: w = '{op: OP_UPDATE, xsel: XSEL_MID, target: STEP_TEST};
      STEP_RESULT: w = '{op: OP_RESULT, xsel: XSEL_MID, target: STEP_WAIT};
      default:     w = '{op: OP_WAIT,   xsel: XSEL_A,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/pbr_if.sv =====
// Ready/valid stream interfaces for the interval words and the result words.
// Depends on pbr_pkg for the word type.
interface pbr_in_if import pbr_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t lower_end;
  word_t upper_end;

  modport source (output valid, output lower_end, output upper_end, input ready);
  modport sink (input valid, input lower_end, input upper_end, output ready);
endinterface

interface pbr_out_if import pbr_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t root;
  logic  no_sign_change;

  modport source (output valid, output root, output no_sign_change, input ready);
  modport sink (input valid, input root, input no_sign_change, output ready);
endinterface

// ===== hw/rtl/pbr_cfg_regs.sv =====
// APB-style register file: polynomial coefficients and stop tolerance.
// Depends on pbr_pkg.
module pbr_cfg_regs import pbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COEFF0: cfg_d.coeff[0] = word_t'(pwdata);
        REG_COEFF1: cfg_d.coeff[1] = word_t'(pwdata);
        REG_COEFF2: cfg_d.coeff[2] = word_t'(pwdata);
        REG_COEFF3: cfg_d.coeff[3] = word_t'(pwdata);
        REG_COEFF4: cfg_d.coeff[4] = word_t'(pwdata);
        REG_TOL:    cfg_d.tolerance = pwdata[TOL_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEFF0: prdata = cfg_q.coeff[0];
      REG_COEFF1: prdata = cfg_q.coeff[1];
      REG_COEFF2: prdata = cfg_q.coeff[2];
      REG_COEFF3: prdata = cfg_q.coeff[3];
      REG_COEFF4: prdata = cfg_q.coeff[4];
      REG_TOL:    prdata = {{(CFG_DATA_W-TOL_W){1'b0}}, cfg_q.tolerance};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff[0]  <= COEFF0_RST;
      cfg_q.coeff[1]  <= COEFF1_RST;
      cfg_q.coeff[2]  <= COEFF2_RST;
      cfg_q.coeff[3]  <= COEFF3_RST;
      cfg_q.coeff[4]  <= COEFF4_RST;
      cfg_q.tolerance <= TOL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/pbr_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on pbr_pkg (ucode_rom, control word and status types).
module pbr_sequencer import pbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output uword_t     ctrl_o
);

  step_t  pc_q, pc_d;
  uword_t uw;
  step_t  pc_inc;

  assign uw     = ucode_rom(pc_q);
  assign ctrl_o = uw;
  assign pc_inc = pc_q + step_t'(1);

  always_comb begin
    pc_d = pc_q;
    unique case (uw.op)
      OP_WAIT:   pc_d = status_i.start ? pc_inc : pc_q;
      OP_ACC:    pc_d = status_i.horner_last ? pc_inc : uw.target;
      OP_CHK_B:  pc_d = status_i.same_sign ? uw.target : pc_inc;
      OP_TEST:   pc_d = status_i.narrow ? uw.target : pc_inc;
      OP_UPDATE: pc_d = uw.target;
      OP_RESULT: pc_d = status_i.slot_free ? uw.target : pc_q;
      OP_LOAD_X, OP_MUL, OP_SIGN_A: pc_d = pc_inc;
      default:   pc_d = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hw/rtl/pbr_datapath.sv =====
// Datapath: interval registers, shared Horner multiply-add unit, sign flags, result register.
// Depends on pbr_pkg and the stream interfaces in pbr_if.sv.
module pbr_datapath import pbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  uword_t     ctrl_i,
  output dp_status_t status_o,
  pbr_in_if.sink     in_if,
  pbr_out_if.source  out_if
);

  word_t                    a_q, a_d, b_q, b_d, x_q, x_d, acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [K_W-1:0]           k_q, k_d;
  logic                     sa_neg_q, sa_neg_d, sa_zero_q, sa_zero_d;
  logic                     nsc_q, nsc_d;
  logic                     out_valid_q, out_valid_d;
  word_t                    root_q, root_d;
  logic                     out_nsc_q, out_nsc_d;

  logic signed [WORD_W:0]   mid_sum, diff;
  word_t                    mid, x_sel, horner;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-WORD_W:0]    sum_hi;
  tol_t                     tol_eff;
  logic                     acc_zero, acc_neg, start, slot_free, same_sign, narrow;

  assign in_if.ready = (ctrl_i.op == OP_WAIT);
  assign start       = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_q || out_if.ready;

  assign mid_sum = $signed({a_q[WORD_W-1], a_q}) + $signed({b_q[WORD_W-1], b_q});
  assign mid     = mid_sum[WORD_W:1];
  assign diff    = $signed({b_q[WORD_W-1], b_q}) - $signed({a_q[WORD_W-1], a_q});
  assign tol_eff = (cfg_i.tolerance == '0) ? tol_t'(1) : cfg_i.tolerance;
  assign narrow  = diff <= $signed({2'b00, tol_eff});

  // floor shift, add next coefficient, saturate to a word
  assign shifted = prod_q >>> FRAC_W;
  assign sum     = $signed(shifted[SUM_W-1:0])
                 + SUM_W'($signed(cfg_i.coeff[COEFF_IDX_W'(k_q)]));
  assign sum_hi  = sum[SUM_W-1:WORD_W-1];
  assign horner  = ((&sum_hi) || !(|sum_hi)) ? sum[WORD_W-1:0]
                 : (sum[SUM_W-1] ? WORD_MIN : WORD_MAX);

  assign acc_zero  = (acc_q == '0);
  assign acc_neg   = acc_q[WORD_W-1];
  assign same_sign = !sa_zero_q && !acc_zero && (sa_neg_q == acc_neg);

  always_comb begin
    unique case (ctrl_i.xsel)
      XSEL_A:   x_sel = a_q;
      XSEL_B:   x_sel = b_q;
      XSEL_MID: x_sel = mid;
      default:  x_sel = a_q;
    endcase
  end

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    k_d         = k_q;
    sa_neg_d    = sa_neg_q;
    sa_zero_d   = sa_zero_q;
    nsc_d       = nsc_q;
    root_d      = root_q;
    out_nsc_d   = out_nsc_q;
    out_valid_d = out_valid_q && !out_if.ready;
    unique case (ctrl_i.op)
      OP_WAIT: begin
        if (start) begin
          a_d   = in_if.lower_end;
          b_d   = in_if.upper_end;
          nsc_d = 1'b0;
        end
      end
      OP_LOAD_X: begin
        x_d   = x_sel;
        acc_d = $signed(cfg_i.coeff[NUM_COEFF-1]);
        k_d   = K_W'(NUM_COEFF - 2);
      end
      OP_MUL: prod_d = acc_q * x_q;
      OP_ACC: begin
        acc_d = horner;
        k_d   = k_q - K_W'(1);
      end
      OP_SIGN_A: begin
        sa_neg_d  = acc_neg;
        sa_zero_d = acc_zero;
      end
      OP_CHK_B: begin
        if (same_sign) begin
          nsc_d = 1'b1;
        end
      end
      OP_TEST: ;
      OP_UPDATE: begin
        if (sa_zero_q || acc_zero || (sa_neg_q != acc_neg)) begin
          b_d = x_q;
        end else begin
          a_d       = x_q;
          sa_neg_d  = acc_neg;
          sa_zero_d = acc_zero;
        end
      end
      OP_RESULT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          root_d      = nsc_q ? '0 : mid;
          out_nsc_d   = nsc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    x_q       <= x_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    k_q       <= k_d;
    sa_neg_q  <= sa_neg_d;
    sa_zero_q <= sa_zero_d;
    nsc_q     <= nsc_d;
    root_q    <= root_d;
    out_nsc_q <= out_nsc_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.root           = root_q;
  assign out_if.no_sign_change = out_nsc_q;

  assign status_o.start       = start;
  assign status_o.horner_last = (k_q == '0);
  assign status_o.same_sign   = same_sign;
  assign status_o.narrow      = narrow;
  assign status_o.slot_free   = slot_free;

endmodule

// ===== hw/rtl/polynomial_bisection_root.sv =====
// Finds a root of a quartic polynomial (signed Q8.24 coefficients set over APB) on an
// interval [lower_end, upper_end] by bisection. One item is worked at a time by a
// microcoded sequencer driving a single 32x32 multiply-add unit; each Horner evaluation
// loads x, then alternates a multiply step and an accumulate step per coefficient. The
// number of halvings is about log2((upper_end - lower_end) / tolerance), 18 at most at the
// default tolerance and 32 at a tolerance of one LSB; when both ends have the same sign,
// no halving is done. A finished result waits in an output register while the next
// interval is accepted.
// Depends on pbr_pkg, pbr_if, pbr_cfg_regs, pbr_sequencer and pbr_datapath.
module polynomial_bisection_root import pbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pbr_in_if.sink                in_if,
  pbr_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  uword_t     ctrl;
  dp_status_t status;

  pbr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbr_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  pbr_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  ap_start_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> ctrl.op == OP_LOAD_X)
    else $error("sequencer did not start evaluation after accept");

  ap_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_MUL |=> ctrl.op == OP_ACC)
    else $error("multiply not followed by accumulate");

  ap_result_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_RESULT && !status.slot_free |=> ctrl.op == OP_RESULT)
    else $error("result step left while output slot full");

  ap_nsc_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.no_sign_change |-> out_if.root == '0)
    else $error("no-sign-change word with nonzero root");

endmodule
